[sv/mqttrx_pkg.sv]
// shared types and codes for the mqtt receive deframer with keepalive
// no dependencies; imported by the core, the top level and the checker
package mqttrx_pkg;

    localparam int unsigned MAX_PACKET_BYTES_DEF = 128;
    localparam int unsigned LEN_W = 28;
    localparam int unsigned IDLE_W = 17;

    localparam logic [15:0] KEEPALIVE_RESET = 16'd15000;
    localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

    // input commands
    localparam logic [1:0] CMD_RX_BYTE = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_SENT    = 2'd2;
    localparam logic [1:0] CMD_OPEN    = 2'd3;

    // result actions
    localparam logic [2:0] ACT_DELIVER  = 3'd0;
    localparam logic [2:0] ACT_PINGRESP = 3'd1;
    localparam logic [2:0] ACT_PONG     = 3'd2;
    localparam logic [2:0] ACT_PINGREQ  = 3'd3;
    localparam logic [2:0] ACT_CLOSE    = 3'd4;

    // packet types
    localparam logic [3:0] TYPE_PUBLISH  = 4'd3;
    localparam logic [3:0] TYPE_PINGREQ  = 4'd12;
    localparam logic [3:0] TYPE_PINGRESP = 4'd13;

    typedef struct packed {
        logic [2:0]       action;
        logic [3:0]       packet_type;
        logic [3:0]       header_flags;
        logic [LEN_W-1:0] remaining_length;
        logic [15:0]      topic_length;
        logic             dropped;
        logic             malformed;
    } result_t;

endpackage

[sv/mqttrx_core.sv]
// parser and keepalive state with the per-item step logic
// depends on mqttrx_pkg
module mqttrx_core #(
    parameter int unsigned MAX_PACKET_BYTES = mqttrx_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_valid,
    input  logic [1:0]          command,
    input  logic [7:0]          rx_byte,
    input  logic [15:0]         keepalive_ticks,
    output logic                res_valid,
    output mqttrx_pkg::result_t res
);
    import mqttrx_pkg::*;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PACKET_BYTES);

    logic              session_reg, session_next;
    logic [1:0]        phase_reg, phase_next;
    logic [7:0]        header_reg, header_next;
    logic [2:0]        count_reg, count_next;
    logic [LEN_W-1:0]  accum_reg, accum_next;
    logic [LEN_W-1:0]  left_reg, left_next;
    logic [15:0]       cap_reg, cap_next;
    logic [IDLE_W-1:0] in_idle_reg, in_idle_next;
    logic [IDLE_W-1:0] out_idle_reg, out_idle_next;
    logic              ping_reg, ping_next;

    logic [LEN_W-1:0]  digit;
    logic [LEN_W-1:0]  pos;
    logic [LEN_W-1:0]  left_dec;
    logic [LEN_W-1:0]  limit;
    logic [IDLE_W-1:0] in_inc, out_inc;
    logic              finish;
    logic              drop;
    logic [3:0]        ptype;

    always_comb begin
        session_next  = session_reg;
        phase_next    = phase_reg;
        header_next   = header_reg;
        count_next    = count_reg;
        accum_next    = accum_reg;
        left_next     = left_reg;
        cap_next      = cap_reg;
        in_idle_next  = in_idle_reg;
        out_idle_next = out_idle_reg;
        ping_next     = ping_reg;
        res_valid     = 1'b0;
        res           = '0;
        finish        = 1'b0;
        drop          = 1'b0;
        limit         = '0;
        ptype         = header_reg[7:4];

        unique case (count_reg[1:0])
            2'd0: digit = {21'b0, rx_byte[6:0]};
            2'd1: digit = {14'b0, rx_byte[6:0], 7'b0};
            2'd2: digit = {7'b0, rx_byte[6:0], 14'b0};
            2'd3: digit = {rx_byte[6:0], 21'b0};
            default: digit = '0;
        endcase
        pos      = accum_reg - left_reg;
        left_dec = left_reg - LEN_W'(1);
        in_inc   = (in_idle_reg == IDLE_MAX) ? in_idle_reg : in_idle_reg + IDLE_W'(1);
        out_inc  = (out_idle_reg == IDLE_MAX) ? out_idle_reg : out_idle_reg + IDLE_W'(1);

        if (step_valid) begin
            if (command == CMD_OPEN) begin
                session_next  = 1'b1;
                phase_next    = PH_HEADER;
                header_next   = '0;
                count_next    = '0;
                accum_next    = '0;
                left_next     = '0;
                cap_next      = '0;
                in_idle_next  = '0;
                out_idle_next = '0;
                ping_next     = 1'b0;
            end else if (session_reg) begin
                if (command == CMD_SENT) begin
                    out_idle_next = '0;
                end else if (command == CMD_TICK) begin
                    in_idle_next  = in_inc;
                    out_idle_next = out_inc;
                    if (in_inc > {1'b0, keepalive_ticks} ||
                        out_inc > {1'b0, keepalive_ticks}) begin
                        res_valid = 1'b1;
                        if (ping_reg) begin
                            session_next = 1'b0;
                            res.action   = ACT_CLOSE;
                        end else begin
                            in_idle_next  = '0;
                            out_idle_next = '0;
                            ping_next     = 1'b1;
                            res.action    = ACT_PINGREQ;
                        end
                    end
                end else if (phase_reg == PH_HEADER) begin
                    header_next = rx_byte;
                    count_next  = '0;
                    accum_next  = '0;
                    left_next   = '0;
                    cap_next    = '0;
                    phase_next  = PH_LENGTH;
                end else if (phase_reg == PH_LENGTH) begin
                    if (count_reg >= 3'd4) begin
                        // a fifth length digit ends the packet as malformed
                        res_valid            = 1'b1;
                        res.action           = ACT_DELIVER;
                        res.packet_type      = header_reg[7:4];
                        res.header_flags     = header_reg[3:0];
                        res.remaining_length = accum_reg;
                        res.malformed        = 1'b1;
                        phase_next           = PH_HEADER;
                        header_next          = '0;
                        count_next           = '0;
                        accum_next           = '0;
                        left_next            = '0;
                        cap_next             = '0;
                    end else begin
                        accum_next = accum_reg + digit;
                        count_next = count_reg + 3'd1;
                        if (!rx_byte[7]) begin
                            if (accum_next == '0) begin
                                finish = 1'b1;
                            end else begin
                                left_next  = accum_next;
                                phase_next = PH_BODY;
                            end
                        end
                    end
                end else begin
                    if (pos == '0) begin
                        cap_next = {rx_byte, 8'h00};
                    end else if (pos == LEN_W'(1)) begin
                        cap_next = {cap_reg[15:8], rx_byte};
                    end
                    left_next = left_dec;
                    if (left_dec == '0) begin
                        finish = 1'b1;
                    end
                end
            end
        end

        if (finish) begin
            // total bytes = header + length digits + body
            limit = MAX_LEN - LEN_W'(count_next) - LEN_W'(1);
            drop  = accum_next > limit;
            res_valid            = 1'b1;
            res.action           = ACT_DELIVER;
            res.packet_type      = ptype;
            res.header_flags     = header_reg[3:0];
            res.remaining_length = accum_next;
            res.dropped          = drop;
            if (ptype == TYPE_PUBLISH && accum_next >= LEN_W'(2)) begin
                res.topic_length = cap_next;
            end
            if (!drop) begin
                in_idle_next = '0;
                if (ptype == TYPE_PINGREQ) begin
                    res.action = ACT_PINGRESP;
                end else if (ptype == TYPE_PINGRESP) begin
                    ping_next  = 1'b0;
                    res.action = ACT_PONG;
                end
            end
            phase_next  = PH_HEADER;
            header_next = '0;
            count_next  = '0;
            accum_next  = '0;
            left_next   = '0;
            cap_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            session_reg  <= 1'b0;
            phase_reg    <= PH_HEADER;
            header_reg   <= '0;
            count_reg    <= '0;
            accum_reg    <= '0;
            left_reg     <= '0;
            cap_reg      <= '0;
            in_idle_reg  <= '0;
            out_idle_reg <= '0;
            ping_reg     <= 1'b0;
        end else begin
            session_reg  <= session_next;
            phase_reg    <= phase_next;
            header_reg   <= header_next;
            count_reg    <= count_next;
            accum_reg    <= accum_next;
            left_reg     <= left_next;
            cap_reg      <= cap_next;
            in_idle_reg  <= in_idle_next;
            out_idle_reg <= out_idle_next;
            ping_reg     <= ping_next;
        end
    end

endmodule

[sv/mqtt_rx_deframer_keepalive.sv]
// Receive deframer for MQTT fixed headers with keepalive supervision. Each transfer on the
// s_ side carries a received byte, a time tick, a sent-packet notice or a session-open
// event; finished packets and keepalive actions leave on the m_ side, at most one per
// transfer. An accepted item sits in the input register and is worked by the step logic
// once the result register is free or draining, and the result register loads at the
// next clock edge; one item is taken every cycle while the m_ side keeps up, and only a
// stalled result register holds back the input. keepalive_ticks is written through
// cfg_wr_en / cfg_wr_data; the user must write it only while no item is in flight, as
// the block does not enforce this. Depends on mqttrx_pkg and mqttrx_core.
module mqtt_rx_deframer_keepalive #(
    parameter int unsigned MAX_PACKET_BYTES = mqttrx_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [15:0]                   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_command,
    input  logic [7:0]                    s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_action,
    output logic [3:0]                    m_packet_type,
    output logic [3:0]                    m_header_flags,
    output logic [mqttrx_pkg::LEN_W-1:0]  m_remaining_length,
    output logic [15:0]                   m_topic_length,
    output logic                          m_dropped,
    output logic                          m_malformed
);
    import mqttrx_pkg::*;

    logic [15:0] keepalive_reg;
    logic        in_valid_reg;
    logic [1:0]  in_command_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic        step;
    logic        res_valid;
    result_t     res;

    // step when an item waits and the result register is free or draining
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    mqttrx_core #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step_valid      (step),
        .command         (in_command_reg),
        .rx_byte         (in_byte_reg),
        .keepalive_ticks (keepalive_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keepalive_reg <= KEEPALIVE_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                keepalive_reg <= cfg_wr_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (step) begin
                out_valid_reg <= res_valid;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_command_reg <= s_command;
            in_byte_reg    <= s_rx_byte;
        end
        if (step && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_action           = out_reg.action;
    assign m_packet_type      = out_reg.packet_type;
    assign m_header_flags     = out_reg.header_flags;
    assign m_remaining_length = out_reg.remaining_length;
    assign m_topic_length     = out_reg.topic_length;
    assign m_dropped          = out_reg.dropped;
    assign m_malformed        = out_reg.malformed;

endmodule

[sv/mqttrx_checker.sv]
// port-level checks for mqtt_rx_deframer_keepalive, bound to the top level
// depends on mqttrx_pkg
module mqttrx_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [2:0]                   m_action,
    input logic [3:0]                   m_packet_type,
    input logic [3:0]                   m_header_flags,
    input logic [mqttrx_pkg::LEN_W-1:0] m_remaining_length,
    input logic [15:0]                  m_topic_length,
    input logic                         m_dropped,
    input logic                         m_malformed
);
    import mqttrx_pkg::*;

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_action_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_action <= ACT_CLOSE))
        else $error("action code out of range");

    a_timer_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_action == ACT_PINGREQ || m_action == ACT_CLOSE) |->
        (m_packet_type == '0 && m_header_flags == '0 && m_remaining_length == '0 &&
         m_topic_length == '0 && !m_dropped && !m_malformed))
        else $error("keepalive action carries packet fields");

    a_ping_not_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_action == ACT_PINGRESP || m_action == ACT_PONG) |->
        (!m_dropped && !m_malformed))
        else $error("ping handling on a dropped or malformed packet");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_action) &&
        $stable(m_remaining_length))
        else $error("result changed while stalled");

endmodule

bind mqtt_rx_deframer_keepalive mqttrx_checker u_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_action           (m_action),
    .m_packet_type      (m_packet_type),
    .m_header_flags     (m_header_flags),
    .m_remaining_length (m_remaining_length),
    .m_topic_length     (m_topic_length),
    .m_dropped          (m_dropped),
    .m_malformed        (m_malformed)
);

[sim/tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for mqtt_rx_deframer_keepalive: directed and random
// byte/tick/notice streams against an in-bench deframer predictor
// depends on mqttrx_pkg and the deframer rtl
module tb;
    import mqttrx_pkg::*;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data;
    } rx_item_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [15:0]       cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_command = CMD_TICK;
    logic [7:0]        s_rx_byte = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [2:0]        m_action;
    logic [3:0]        m_packet_type;
    logic [3:0]        m_header_flags;
    logic [LEN_W-1:0]  m_remaining_length;
    logic [15:0]       m_topic_length;
    logic              m_dropped;
    logic              m_malformed;

    mqtt_rx_deframer_keepalive dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_rx_byte          (s_rx_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_action           (m_action),
        .m_packet_type      (m_packet_type),
        .m_header_flags     (m_header_flags),
        .m_remaining_length (m_remaining_length),
        .m_topic_length     (m_topic_length),
        .m_dropped          (m_dropped),
        .m_malformed        (m_malformed)
    );

    rx_item_t rx_stream[$];
    result_t  predicted_results[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left = 0;
    int unsigned queued = 0;
    int unsigned errors = 0;
    int unsigned n_in = 0, n_out = 0, n_dropped = 0, n_malformed = 0;
    int unsigned n_pingreq = 0, n_close = 0, n_pong = 0;

    // predictor state
    logic             sess_open = 1'b0;
    logic [1:0]       parse_phase = PH_HEADER;
    logic [7:0]       hdr_byte = '0;
    int unsigned      n_digits = 0;
    logic [LEN_W-1:0] len_accum = '0;
    logic [LEN_W-1:0] body_left = '0;
    logic [15:0]      topic_cap = '0;
    logic [IDLE_W-1:0] in_idle = '0;
    logic [IDLE_W-1:0] out_idle = '0;
    logic             ping_pending = 1'b0;
    logic [15:0]      keepalive = KEEPALIVE_RESET;

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic void parser_restart();
        parse_phase = PH_HEADER;
        hdr_byte = '0;
        n_digits = 0;
        len_accum = '0;
        body_left = '0;
        topic_cap = '0;
    endfunction

    function automatic result_t packet_done();
        result_t r;
        logic    drop;
        r = '0;
        drop = (len_accum > MAX_PACKET_BYTES_DEF - (1 + n_digits));
        r.action = ACT_DELIVER;
        r.packet_type = hdr_byte[7:4];
        r.header_flags = hdr_byte[3:0];
        r.remaining_length = len_accum;
        if (hdr_byte[7:4] == TYPE_PUBLISH && len_accum >= 2)
            r.topic_length = topic_cap;
        r.dropped = drop;
        // oversize packets are not inbound activity
        if (!drop) begin
            in_idle = '0;
            if (hdr_byte[7:4] == TYPE_PINGREQ) begin
                r.action = ACT_PINGRESP;
            end else if (hdr_byte[7:4] == TYPE_PINGRESP) begin
                ping_pending = 1'b0;
                r.action = ACT_PONG;
            end
        end
        parser_restart();
        return r;
    endfunction

    function automatic bit deframe_step(input logic [1:0] cmd, input logic [7:0] b,
                                        output result_t r);
        logic [LEN_W-1:0] pos;
        r = '0;
        if (cmd == CMD_OPEN) begin
            sess_open = 1'b1;
            parser_restart();
            in_idle = '0;
            out_idle = '0;
            ping_pending = 1'b0;
            return 1'b0;
        end
        if (!sess_open)
            return 1'b0;
        if (cmd == CMD_SENT) begin
            out_idle = '0;
            return 1'b0;
        end
        if (cmd == CMD_TICK) begin
            if (in_idle != IDLE_MAX)
                in_idle = in_idle + 1'b1;
            if (out_idle != IDLE_MAX)
                out_idle = out_idle + 1'b1;
            if (in_idle > keepalive || out_idle > keepalive) begin
                if (ping_pending) begin
                    sess_open = 1'b0;
                    r.action = ACT_CLOSE;
                end else begin
                    in_idle = '0;
                    out_idle = '0;
                    ping_pending = 1'b1;
                    r.action = ACT_PINGREQ;
                end
                return 1'b1;
            end
            return 1'b0;
        end
        case (parse_phase)
            PH_HEADER: begin
                parser_restart();
                hdr_byte = b;
                parse_phase = PH_LENGTH;
                return 1'b0;
            end
            PH_LENGTH: begin
                // a fifth length digit ends the packet as malformed
                if (n_digits >= 4) begin
                    r.action = ACT_DELIVER;
                    r.packet_type = hdr_byte[7:4];
                    r.header_flags = hdr_byte[3:0];
                    r.remaining_length = len_accum;
                    r.malformed = 1'b1;
                    parser_restart();
                    return 1'b1;
                end
                len_accum = len_accum + ({21'd0, b[6:0]} << (7 * n_digits));
                n_digits = n_digits + 1;
                if (b[7])
                    return 1'b0;
                if (len_accum == 0) begin
                    r = packet_done();
                    return 1'b1;
                end
                body_left = len_accum;
                parse_phase = PH_BODY;
                return 1'b0;
            end
            default: begin
                pos = len_accum - body_left;
                if (pos == 0)
                    topic_cap = {b, 8'h00};
                else if (pos == 1)
                    topic_cap[7:0] = b;
                body_left = body_left - 1'b1;
                if (body_left == 0) begin
                    r = packet_done();
                    return 1'b1;
                end
                return 1'b0;
            end
        endcase
    endfunction

    // stimulus helpers
    function automatic logic [7:0] rand_byte();
        logic [31:0] v;
        v = $urandom;
        return v[7:0];
    endfunction

    function automatic void push_item(input logic [1:0] cmd, input logic [7:0] b);
        rx_item_t it;
        it.command = cmd;
        it.data = b;
        rx_stream.push_back(it);
        queued++;
    endfunction

    function automatic void push_packet();
        int         pick, len, ndig, k, d;
        logic [7:0] hb;
        pick = $urandom_range(99);
        hb = rand_byte();
        if (pick < 30)
            hb[7:4] = TYPE_PUBLISH;
        else if (pick < 42)
            hb[7:4] = TYPE_PINGREQ;
        else if (pick < 54)
            hb[7:4] = TYPE_PINGRESP;
        push_item(CMD_RX_BYTE, hb);
        pick = $urandom_range(99);
        if (pick < 6) begin
            repeat (4) push_item(CMD_RX_BYTE, rand_byte() | 8'h80);
            push_item(CMD_RX_BYTE, rand_byte());
            return;
        end
        if (pick < 52)
            len = $urandom_range(6);
        else if (pick < 78)
            len = $urandom_range(30, 7);
        else if (pick < 87)
            len = $urandom_range(135, 120);
        else if (pick < 90)
            len = $urandom_range(300, 136);
        else
            len = $urandom_range(3);
        ndig = (len < 128) ? 1 : 2;
        // non-minimal length encodings, also around the drop boundary
        if (pick >= 90)
            ndig = $urandom_range(4, 2);
        else if (pick >= 78 && $urandom_range(3) == 0)
            ndig = 2;
        for (k = 0; k < ndig; k++) begin
            d = (len >> (7 * k)) & 127;
            if (k < ndig - 1)
                d = d | 128;
            push_item(CMD_RX_BYTE, d[7:0]);
        end
        for (k = 0; k < len; k++) begin
            pick = $urandom_range(99);
            if (pick < 3)
                push_item(CMD_TICK, rand_byte());
            else if (pick < 5)
                push_item(CMD_SENT, rand_byte());
            push_item(CMD_RX_BYTE, rand_byte());
        end
    endfunction

    function automatic void gen_traffic(input int unsigned n);
        int unsigned start;
        int          pick;
        start = queued;
        while (queued - start < n) begin
            pick = $urandom_range(99);
            if (pick < 10)
                push_item(CMD_TICK, rand_byte());
            else if (pick < 16)
                push_item(CMD_SENT, rand_byte());
            else if (pick < 18)
                push_item(CMD_OPEN, rand_byte());
            else if (pick < 22)
                push_item(CMD_RX_BYTE, rand_byte());
            else
                push_packet();
        end
    endfunction

    task automatic wait_drained();
        do @(negedge aclk);
        while (rx_stream.size() != 0 || s_valid || predicted_results.size() != 0);
    endtask

    task automatic write_keepalive(input logic [15:0] v);
        wait_drained();
        // let a trailing no-result item clear the pipeline
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        keepalive = v;
    endtask

    // driver
    always @(posedge aclk) begin
        rx_item_t nxt;
        result_t  res;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                n_in++;
                if (deframe_step(s_command, s_rx_byte, res))
                    predicted_results.push_back(res);
            end
            if (!s_valid || s_ready) begin
                if (rx_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = rx_stream.pop_front();
                    s_valid <= 1'b1;
                    s_command <= nxt.command;
                    s_rx_byte <= nxt.data;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void compare_field(input string name, input logic [27:0] want,
                                          input logic [27:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // monitor
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got action %0d",
                             $time, m_action);
                    errors++;
                end else begin
                    want = predicted_results.pop_front();
                    n_out++;
                    if (want.dropped) n_dropped++;
                    if (want.malformed) n_malformed++;
                    if (want.action == ACT_PINGREQ) n_pingreq++;
                    if (want.action == ACT_CLOSE) n_close++;
                    if (want.action == ACT_PONG) n_pong++;
                    compare_field("action", 28'(want.action), 28'(m_action));
                    compare_field("packet_type", 28'(want.packet_type), 28'(m_packet_type));
                    compare_field("header_flags", 28'(want.header_flags),
                                  28'(m_header_flags));
                    compare_field("remaining_length", want.remaining_length,
                                  m_remaining_length);
                    compare_field("topic_length", 28'(want.topic_length),
                                  28'(m_topic_length));
                    compare_field("dropped", 28'(want.dropped), 28'(m_dropped));
                    compare_field("malformed", 28'(want.malformed), 28'(m_malformed));
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // closed session ignores everything but open
        push_item(CMD_RX_BYTE, 8'hFF);
        push_item(CMD_TICK, 8'h00);
        push_item(CMD_SENT, 8'hA5);
        push_item(CMD_OPEN, 8'h5A);
        push_item(CMD_RX_BYTE, {TYPE_PINGREQ, 4'h0});
        push_item(CMD_RX_BYTE, 8'h00);
        push_item(CMD_RX_BYTE, {TYPE_PUBLISH, 4'hB});
        push_item(CMD_RX_BYTE, 8'h04);
        push_item(CMD_RX_BYTE, 8'h12);
        push_item(CMD_RX_BYTE, 8'h34);
        push_item(CMD_RX_BYTE, 8'hAA);
        push_item(CMD_RX_BYTE, 8'h55);
        // publish too short to carry a topic length
        push_item(CMD_RX_BYTE, {TYPE_PUBLISH, 4'h0});
        push_item(CMD_RX_BYTE, 8'h01);
        push_item(CMD_RX_BYTE, 8'hFF);
        // fifth length digit, full 28-bit length
        push_item(CMD_RX_BYTE, 8'h2F);
        repeat (4) push_item(CMD_RX_BYTE, 8'hFF);
        push_item(CMD_RX_BYTE, 8'h00);
        push_item(CMD_SENT, 8'h00);
        push_item(CMD_RX_BYTE, {TYPE_PINGRESP, 4'h0});
        push_item(CMD_RX_BYTE, 8'h00);
        // zero length in two digits
        push_item(CMD_RX_BYTE, 8'h10);
        push_item(CMD_RX_BYTE, 8'h80);
        push_item(CMD_RX_BYTE, 8'h00);

        // ping then close on the shortest interval
        write_keepalive(16'd1);
        push_item(CMD_OPEN, 8'h00);
        repeat (4) push_item(CMD_TICK, rand_byte());
        push_item(CMD_RX_BYTE, 8'hC0);
        write_keepalive(16'd0);
        push_item(CMD_OPEN, 8'hFF);
        repeat (2) push_item(CMD_TICK, rand_byte());

        write_keepalive(16'($urandom_range(12, 2)));
        push_item(CMD_OPEN, rand_byte());
        gen_traffic(250);

        write_keepalive(16'hFFFF);
        send_idle_pct = 85;
        push_item(CMD_OPEN, rand_byte());
        gen_traffic(200);

        write_keepalive(16'($urandom_range(40, 3)));
        send_idle_pct = 0;
        recv_stall_pct = 85;
        push_item(CMD_OPEN, rand_byte());
        gen_traffic(250);

        // long receiver hold-off while short packets keep coming
        wait_drained();
        recv_stall_pct = 0;
        hold_left = 150;
        push_item(CMD_OPEN, rand_byte());
        repeat (40) begin
            push_item(CMD_RX_BYTE, rand_byte());
            push_item(CMD_RX_BYTE, 8'h00);
        end
        wait_drained();

        write_keepalive(16'($urandom_range(8, 1)));
        send_idle_pct = 18;
        recv_stall_pct = 18;
        push_item(CMD_OPEN, rand_byte());
        gen_traffic(300);

        wait_drained();
        repeat (10) @(posedge aclk);
        $display("covered %0d transfers in, %0d results out: %0d dropped, %0d malformed,",
                 n_in, n_out, n_dropped, n_malformed);
        $display("%0d pings sent, %0d answered, %0d timeout closes, %0d errors",
                 n_pingreq, n_pong, n_close, errors);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
sv/mqttrx_pkg.sv
sv/mqttrx_core.sv
sv/mqtt_rx_deframer_keepalive.sv
sv/mqttrx_checker.sv
sim/tb.sv
